/* rtl/projected_bounds_visibility_test_top_macros.svh */
// Assertion macros for the projected bounds visibility test checker.
// Needs a clk and rst in scope where the macros are used.
`ifndef PROJECTED_BOUNDS_VISIBILITY_TEST_TOP_MACROS_SVH
`define PROJECTED_BOUNDS_VISIBILITY_TEST_TOP_MACROS_SVH

// same-cycle implication
`define PBV_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication
`define PBV_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

/* rtl/pbv_pkg.sv */
// Shared constants and sequencer states for the projected bounds visibility test.
// No dependencies.
`timescale 1ns / 1ps
package pbv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 4;
  localparam int CFG_W     = 64;
  localparam int ACC_W     = 64;

  localparam logic signed [COORD_W-1:0] Q_ONE = COORD_W'(1) <<< FRAC_BITS;
  localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MTAIL,
    ST_DABS,
    ST_DCHK,
    ST_DITER,
    ST_DEND,
    ST_EMIT
  } state_t;

endpackage

/* rtl/projected_bounds_visibility_test_top.sv */
// Projected bounds visibility test: matrix transform, perspective divide,
// running bounds and view-volume flag. Depends on pbv_pkg.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index picks one of
//   eight 64-bit matrix registers (two Q16.16 elements each), cfg_data the
//   value. Indexes past the list are dropped. cfg_ready is always high.
//   Input: one vertex word per handshake on s_*; s_tlast marks the last
//   vertex of a mesh. Output: one word per mesh on m_*, after its last vertex.
//   Timing: s_tready stays low after a vertex is taken until its last divide
//   ends (on a marked vertex also through the emit state, plus any output
//   stall): the single 32x32 multiplier forms the sixteen matrix products, a
//   tail step folds in the last product, then three perspective divides run
//   through one restoring divider that yields one quotient bit a cycle (its
//   iterations are skipped when the divisor is zero or the quotient overflows).
//   The emit state registers the bounds word after the marked vertex's last divide.
//   Reset: matrix returns to identity, bounds clear, no word pending.
//   Stall: a pending output word holds in the output register; the block
//   keeps taking vertices, and only a further last vertex waits for it.
`timescale 1ns / 1ps
module projected_bounds_visibility_test_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // vert_x, vert_y, vert_z
  input  logic         s_tlast,   // is_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  output logic         m_tuser    // visible
);

  localparam int F  = pbv_pkg::FRAC_BITS;
  localparam int CW = pbv_pkg::COORD_W;
  localparam int AW = pbv_pkg::ACC_W;
  localparam int SH = CW - F;

  pbv_pkg::state_t state, state_next;

  logic [pbv_pkg::CFG_W-1:0] mreg [pbv_pkg::NUM_REGS];

  logic [3:0]                cnt;
  logic                      pvalid;
  logic [1:0]                prow;
  logic signed [AW-1:0]      preg;
  logic [AW-1:0]             sums [4];
  logic signed [CW-1:0]      vx, vy, vz;
  logic                      vlast;

  logic [1:0]                axis;
  logic [AW-1:0]             a, b, rem;
  logic                      neg, nneg, zero, ov;
  logic [CW-1:0]             dl, q;
  logic [4:0]                itc;

  logic signed [CW-1:0]      lo [3];
  logic signed [CW-1:0]      hi [3];

  logic signed [CW-1:0]      elem, vec;
  logic [CW-1:0]             half_sel;
  logic [AW-1:0]             num;
  logic [AW:0]               rsh;
  logic                      qbit;
  logic [CW-1:0]             lim, mag;
  logic signed [CW-1:0]      res;
  logic                      vis;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == pbv_pkg::ST_IDLE);

  function automatic logic axis_ok(input logic signed [CW-1:0] l,
                                   input logic signed [CW-1:0] h,
                                   input logic signed [CW-1:0] rlo);
    logic straddle, l_in, h_in;
    straddle = (l < 0 && h > 0) || (l > 0 && h < 0);
    l_in     = (l >= rlo) && (l <= pbv_pkg::Q_ONE);
    h_in     = (h >= rlo) && (h <= pbv_pkg::Q_ONE);
    return straddle || l_in || h_in;
  endfunction

  function automatic logic zero_chk();
    return (b == '0);
  endfunction

  function automatic logic ov_chk();
    return ({{CW{1'b0}}, a} >= ({{CW{1'b0}}, b} << SH));
  endfunction

  // operand selection for the shared multiplier
  always_comb begin
    half_sel = cnt[0] ? mreg[cnt[3:1]][2*CW-1:CW] : mreg[cnt[3:1]][CW-1:0];
    elem     = signed'(half_sel);
    case (cnt[1:0])
      2'd0:    vec = vx;
      2'd1:    vec = vy;
      2'd2:    vec = vz;
      default: vec = pbv_pkg::Q_ONE;
    endcase
  end

  // divider step and result shaping
  always_comb begin
    num  = sums[axis];
    rsh  = {rem, dl[CW-1]};
    qbit = (rsh >= {1'b0, b});
    lim  = neg ? pbv_pkg::Q_MIN : pbv_pkg::Q_MAX;
    mag  = (ov || (q > lim)) ? lim : q;
    if (zero) begin
      res = (a == '0) ? '0 : (nneg ? pbv_pkg::Q_MIN : pbv_pkg::Q_MAX);
    end else begin
      res = neg ? signed'(CW'(-mag)) : signed'(mag);
    end
    vis = axis_ok(lo[0], hi[0], -pbv_pkg::Q_ONE) &&
          axis_ok(lo[1], hi[1], -pbv_pkg::Q_ONE) &&
          axis_ok(lo[2], hi[2], '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      pbv_pkg::ST_IDLE:  if (s_tvalid) state_next = pbv_pkg::ST_MUL;
      pbv_pkg::ST_MUL:   if (cnt == 4'd15) state_next = pbv_pkg::ST_MTAIL;
      pbv_pkg::ST_MTAIL: state_next = pbv_pkg::ST_DABS;
      pbv_pkg::ST_DABS:  state_next = pbv_pkg::ST_DCHK;
      pbv_pkg::ST_DCHK:  state_next = (zero_chk() || ov_chk()) ? pbv_pkg::ST_DEND
                                                             : pbv_pkg::ST_DITER;
      pbv_pkg::ST_DITER: if (itc == 5'd31) state_next = pbv_pkg::ST_DEND;
      pbv_pkg::ST_DEND: begin
        if (axis != 2'd2) state_next = pbv_pkg::ST_DABS;
        else state_next = vlast ? pbv_pkg::ST_EMIT : pbv_pkg::ST_IDLE;
      end
      pbv_pkg::ST_EMIT:  if (!m_tvalid || m_tready) state_next = pbv_pkg::ST_IDLE;
      default:           state_next = pbv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pbv_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= pbv_pkg::CFG_W'(pbv_pkg::Q_ONE);
      mreg[1] <= '0;
      mreg[2] <= pbv_pkg::CFG_W'(pbv_pkg::Q_ONE) << CW;
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= pbv_pkg::CFG_W'(pbv_pkg::Q_ONE);
      mreg[6] <= '0;
      mreg[7] <= pbv_pkg::CFG_W'(pbv_pkg::Q_ONE) << CW;
    end else if (cfg_valid && cfg_index < pbv_pkg::IDX_W'(pbv_pkg::NUM_REGS)) begin
      mreg[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pvalid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo[i] <= pbv_pkg::Q_MAX;
        hi[i] <= pbv_pkg::Q_MIN;
      end
    end else begin
      // drop the word once taken, unless a new one replaces it this cycle
      if (m_tvalid && m_tready && state != pbv_pkg::ST_EMIT) m_tvalid <= 1'b0;
      case (state)
        pbv_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            vx    <= signed'(s_tdata[CW-1:0]);
            vy    <= signed'(s_tdata[2*CW-1:CW]);
            vz    <= signed'(s_tdata[3*CW-1:2*CW]);
            vlast <= s_tlast;
            cnt   <= '0;
            for (int i = 0; i < 4; i++) sums[i] <= '0;
            pvalid <= 1'b0;
          end
        end
        pbv_pkg::ST_MUL: begin
          preg   <= elem * vec;
          prow   <= cnt[3:2];
          pvalid <= 1'b1;
          cnt    <= cnt + 4'd1;
          if (pvalid) sums[prow] <= sums[prow] + AW'(preg >>> F);
        end
        pbv_pkg::ST_MTAIL: begin
          sums[prow] <= sums[prow] + AW'(preg >>> F);
          pvalid     <= 1'b0;
          axis       <= '0;
        end
        pbv_pkg::ST_DABS: begin
          nneg <= num[AW-1];
          neg  <= num[AW-1] ^ sums[3][AW-1];
          a    <= num[AW-1] ? AW'(-num) : num;
          b    <= sums[3][AW-1] ? AW'(-sums[3]) : sums[3];
        end
        pbv_pkg::ST_DCHK: begin
          zero <= zero_chk();
          ov   <= ov_chk();
          rem  <= a >> SH;
          dl   <= a[CW-1:0] << F;
          q    <= '0;
          itc  <= '0;
        end
        pbv_pkg::ST_DITER: begin
          rem <= qbit ? AW'(rsh - {1'b0, b}) : rsh[AW-1:0];
          q   <= {q[CW-2:0], qbit};
          dl  <= dl << 1;
          itc <= itc + 5'd1;
        end
        pbv_pkg::ST_DEND: begin
          if (res < lo[axis]) lo[axis] <= res;
          if (res > hi[axis]) hi[axis] <= res;
          axis <= axis + 2'd1;
        end
        pbv_pkg::ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= vis;
            m_tdata  <= {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
            for (int i = 0; i < 3; i++) begin
              lo[i] <= pbv_pkg::Q_MAX;
              hi[i] <= pbv_pkg::Q_MIN;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pbv_checker.sv */
// Port-level checks for the projected bounds visibility test, bound to the top.
// Depends on pbv_pkg and the macro header.
`timescale 1ns / 1ps
`include "projected_bounds_visibility_test_top_macros.svh"
module pbv_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  localparam int CW = pbv_pkg::COORD_W;

  logic signed [CW-1:0] lo_x, hi_x;
  assign lo_x = signed'(m_tdata[CW-1:0]);
  assign hi_x = signed'(m_tdata[4*CW-1:3*CW]);

  `PBV_CHK_NEXT(out_hold, m_tvalid && !m_tready, m_tvalid)
  `PBV_CHK_NEXT(out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  `PBV_CHK_NEXT(busy_after_take, s_tvalid && s_tready, !s_tready)
  `PBV_CHK_NOW(bounds_order, m_tvalid, lo_x <= hi_x)
  `PBV_CHK_NOW(cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind projected_bounds_visibility_test_top pbv_checker u_pbv_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
